// ===== rtl/core/sbq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_pkg
// Shared types and constants for the smoothed biquad filter: controller
// states, datapath command and status structs, and register indexes.
// ----------------------------------------------------------------------------
package sbq_pkg;

  localparam int unsigned COEF_BITS  = 32;
  localparam int unsigned DELAY_BITS = 40;
  localparam int unsigned NUM_COEF   = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned FLOOR_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_A2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 3'd6;

  localparam logic [SHIFT_W-1:0] SMOOTH_RESET = 4'd6;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET  = 16'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL_B0,
    ST_ADD_Y,
    ST_ADD_B1,
    ST_SUB_A1,
    ST_ADD_B2,
    ST_SUB_A2,
    ST_FINISH
  } ctrl_state_e;

  typedef enum logic [2:0] {
    MUL_B0_X,
    MUL_B1_X,
    MUL_A1_Y,
    MUL_B2_X,
    MUL_A2_Y
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_Y,
    ACC_N1_LOAD,
    ACC_N1_SUB,
    ACC_N2_LOAD,
    ACC_N2_SUB
  } acc_op_e;

  typedef struct packed {
    logic     load_in;
    logic     coef_step;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     commit;
  } sbq_cmd_t;

  typedef struct packed {
    logic out_full;
  } sbq_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/smoothed_biquad_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smoothed_biquad_filter
// Transposed direct form II biquad with smoothed coefficients, fixed point.
//
// Input stream: each transfer carries one sample in tdata and the clear flag
// in tuser. Output stream: one transfer per input transfer, the filtered
// sample in tdata and the overflow flag in tuser.
// Coefficient targets, smoothing shift and flush floor are written through
// the cfg port while the filter is idle; the user must keep to this, as the
// block itself does not enforce it. A new item is taken only after the last
// one is committed. The single shared multiplier performs five products in
// sequence after the coefficient update; a clear item skips them.
// The next sample is accepted while a result still waits in the output
// register; a stalled receiver holds the result, and the filter then waits
// in its final step until the output register is free.
// Reset returns all targets and working coefficients to a unity filter,
// clears the delay terms and empties the output register.
// ----------------------------------------------------------------------------
module smoothed_biquad_filter
  import sbq_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned COEF_FRAC_BITS = 28
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]                 cfg_idx_i,
  input  wire logic [COEF_BITS-1:0]                 cfg_data_i,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // Bits from the lowest: sample_in, then zero fill.
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // Bits from the lowest: clear.
  input  wire logic                                 s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // Bits from the lowest: sample_out, then zero fill.
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]          m_axis_tdata,
  // Bits from the lowest: overflow.
  output logic                                      m_axis_tuser
);

  localparam int unsigned TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  sbq_cmd_t               cmd;
  sbq_status_t            status;
  logic [SAMPLE_BITS-1:0] out_sample;

  sbq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_clear_i (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sbq_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_sample_i    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_clear_i     (s_axis_tuser),
    .cmd_i          (cmd),
    .out_ready_i    (m_axis_tready),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid),
    .out_sample_o   (out_sample),
    .out_overflow_o (m_axis_tuser)
  );

  assign m_axis_tdata = TDATA_W'(out_sample);

  // An overflowed result always carries a zero sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (out_sample == '0))
    else $error("overflow result with nonzero sample");

  // Only one item is in flight: after a transfer in, the input is not ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // A result is committed only when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result committed over a pending transfer");

  // Coefficients never move on the cycle an item is taken in.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_in |-> (!cmd.coef_step && !cmd.commit))
    else $error("conflicting datapath commands");

endmodule
`default_nettype wire

// ===== rtl/core/sbq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_ctrl
// Sequencer for the biquad: steps one sample through coefficient update, five
// shared multiplications and the final commit; a clear item skips to the commit.
// ----------------------------------------------------------------------------
module sbq_ctrl
  import sbq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_clear_i,
  output logic             in_ready_o,
  input  wire sbq_status_t status_i,
  output sbq_cmd_t         cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.load_in   = 1'b0;
    cmd_o.coef_step = 1'b0;
    cmd_o.mul_sel   = MUL_B0_X;
    cmd_o.acc_op    = ACC_NONE;
    cmd_o.commit    = 1'b0;
    in_ready_o      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = in_clear_i ? ST_FINISH : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.coef_step = 1'b1;
        state_d = ST_MUL_B0;
      end
      ST_MUL_B0: begin
        cmd_o.mul_sel = MUL_B0_X;
        state_d = ST_ADD_Y;
      end
      ST_ADD_Y: begin
        cmd_o.acc_op  = ACC_Y;
        cmd_o.mul_sel = MUL_B1_X;
        state_d = ST_ADD_B1;
      end
      ST_ADD_B1: begin
        cmd_o.acc_op  = ACC_N1_LOAD;
        cmd_o.mul_sel = MUL_A1_Y;
        state_d = ST_SUB_A1;
      end
      ST_SUB_A1: begin
        cmd_o.acc_op  = ACC_N1_SUB;
        cmd_o.mul_sel = MUL_B2_X;
        state_d = ST_ADD_B2;
      end
      ST_ADD_B2: begin
        cmd_o.acc_op  = ACC_N2_LOAD;
        cmd_o.mul_sel = MUL_A2_Y;
        state_d = ST_SUB_A2;
      end
      ST_SUB_A2: begin
        cmd_o.acc_op = ACC_N2_SUB;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status_i.out_full) begin
          cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/sbq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_datapath
// Configuration registers, smoothed coefficients, delay terms, one shared
// registered multiplier with rounding, accumulators and the output register.
// ----------------------------------------------------------------------------
module sbq_datapath
  import sbq_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned COEF_FRAC_BITS = 28
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [COEF_BITS-1:0]   cfg_data_i,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_i,
  input  wire logic                   in_clear_i,
  input  wire sbq_cmd_t               cmd_i,
  input  wire logic                   out_ready_i,
  output sbq_status_t                 status_o,
  output logic                        out_valid_o,
  output logic [SAMPLE_BITS-1:0]      out_sample_o,
  output logic                        out_overflow_o
);

  localparam int unsigned PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam int unsigned SC_W   = PROD_W + 1 - COEF_FRAC_BITS;
  localparam int unsigned ACC_W  = COEF_BITS + SAMPLE_BITS + 2;
  localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;
  localparam logic signed [PROD_W:0] ROUND_HALF =
    (PROD_W + 1)'(1) << (COEF_FRAC_BITS - 1);

  logic signed [COEF_BITS-1:0]   target_q [NUM_COEF];
  logic signed [COEF_BITS-1:0]   coef_q   [NUM_COEF];
  logic signed [COEF_BITS-1:0]   coef_d   [NUM_COEF];
  logic [SHIFT_W-1:0]            shift_q;
  logic [FLOOR_W-1:0]            floor_q;
  logic signed [DELAY_BITS-1:0]  z1_q, z2_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic                          clear_q;
  logic signed [PROD_W-1:0]      prod_q, prod_d;
  logic signed [COEF_BITS-1:0]   mul_coef;
  logic signed [SAMPLE_BITS-1:0] mul_opnd;
  logic signed [PROD_W:0]        rounded;
  logic signed [ACC_W-1:0]       scaled, z1_ext, z2_ext, floor_ext;
  logic signed [ACC_W-1:0]       acc_y_q, acc_n1_q, acc_n2_q;
  logic signed [ACC_W-1:0]       n1_flush, n2_flush;
  logic                          y_fits, n1_fits, n2_fits, ovf;
  logic                          out_valid_q, out_ovf_q;
  logic [SAMPLE_BITS-1:0]        out_sample_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q[0] <= COEF_ONE;
      target_q[1] <= '0;
      target_q[2] <= '0;
      target_q[3] <= '0;
      target_q[4] <= '0;
      shift_q     <= SMOOTH_RESET;
      floor_q     <= FLOOR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET_B0: target_q[0] <= cfg_data_i;
        REG_TARGET_B1: target_q[1] <= cfg_data_i;
        REG_TARGET_B2: target_q[2] <= cfg_data_i;
        REG_TARGET_A1: target_q[3] <= cfg_data_i;
        REG_TARGET_A2: target_q[4] <= cfg_data_i;
        REG_SMOOTH:    shift_q     <= cfg_data_i[SHIFT_W-1:0];
        REG_FLOOR:     floor_q     <= cfg_data_i[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  // One-pole smoothing step with a floor shift; the result lies between the
  // working value and the target, so it always fits the coefficient width.
  always_comb begin
    logic signed [COEF_BITS:0] diff;
    logic signed [COEF_BITS:0] step;
    logic signed [COEF_BITS:0] sum;
    for (int i = 0; i < NUM_COEF; i++) begin
      diff = {target_q[i][COEF_BITS-1], target_q[i]} - {coef_q[i][COEF_BITS-1], coef_q[i]};
      step = diff >>> shift_q;
      sum  = {coef_q[i][COEF_BITS-1], coef_q[i]} + step;
      coef_d[i] = sum[COEF_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= COEF_ONE;
      coef_q[1] <= '0;
      coef_q[2] <= '0;
      coef_q[3] <= '0;
      coef_q[4] <= '0;
    end else if (cmd_i.coef_step) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_q[i] <= coef_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q     <= in_sample_i;
      clear_q <= in_clear_i;
    end
  end

  // Shared multiplier. The y operand is the low sample bits of the output
  // sum; when those do not hold y the item overflows regardless.
  always_comb begin
    mul_coef = coef_q[0];
    mul_opnd = x_q;
    case (cmd_i.mul_sel)
      MUL_B0_X: begin
        mul_coef = coef_q[0];
        mul_opnd = x_q;
      end
      MUL_B1_X: begin
        mul_coef = coef_q[1];
        mul_opnd = x_q;
      end
      MUL_A1_Y: begin
        mul_coef = coef_q[3];
        mul_opnd = acc_y_q[SAMPLE_BITS-1:0];
      end
      MUL_B2_X: begin
        mul_coef = coef_q[2];
        mul_opnd = x_q;
      end
      MUL_A2_Y: begin
        mul_coef = coef_q[4];
        mul_opnd = acc_y_q[SAMPLE_BITS-1:0];
      end
      default: begin
        mul_coef = coef_q[0];
        mul_opnd = x_q;
      end
    endcase
  end

  assign prod_d = PROD_W'(mul_coef) * PROD_W'(mul_opnd);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign rounded   = {prod_q[PROD_W-1], prod_q} + ROUND_HALF;
  assign scaled    = {{(ACC_W - SC_W){rounded[PROD_W]}}, rounded[PROD_W:COEF_FRAC_BITS]};
  assign z1_ext    = {{(ACC_W - DELAY_BITS){z1_q[DELAY_BITS-1]}}, z1_q};
  assign z2_ext    = {{(ACC_W - DELAY_BITS){z2_q[DELAY_BITS-1]}}, z2_q};
  assign floor_ext = {{(ACC_W - FLOOR_W){1'b0}}, floor_q};

  always_ff @(posedge clk_i) begin
    case (cmd_i.acc_op)
      ACC_Y:       acc_y_q  <= scaled + z1_ext;
      ACC_N1_LOAD: acc_n1_q <= scaled + z2_ext;
      ACC_N1_SUB:  acc_n1_q <= acc_n1_q - scaled;
      ACC_N2_LOAD: acc_n2_q <= scaled;
      ACC_N2_SUB:  acc_n2_q <= acc_n2_q - scaled;
      default: ;
    endcase
  end

  assign n1_flush = (acc_n1_q < floor_ext && acc_n1_q > -floor_ext) ? '0 : acc_n1_q;
  assign n2_flush = (acc_n2_q < floor_ext && acc_n2_q > -floor_ext) ? '0 : acc_n2_q;

  assign y_fits  = (&acc_y_q[ACC_W-1:SAMPLE_BITS-1]) | ~(|acc_y_q[ACC_W-1:SAMPLE_BITS-1]);
  assign n1_fits = (&n1_flush[ACC_W-1:DELAY_BITS-1]) | ~(|n1_flush[ACC_W-1:DELAY_BITS-1]);
  assign n2_fits = (&n2_flush[ACC_W-1:DELAY_BITS-1]) | ~(|n2_flush[ACC_W-1:DELAY_BITS-1]);
  assign ovf     = ~(y_fits & n1_fits & n2_fits);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z1_q <= '0;
      z2_q <= '0;
    end else if (cmd_i.commit) begin
      if (clear_q || ovf) begin
        z1_q <= '0;
        z2_q <= '0;
      end else begin
        z1_q <= n1_flush[DELAY_BITS-1:0];
        z2_q <= n2_flush[DELAY_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (clear_q) begin
        out_sample_q <= '0;
        out_ovf_q    <= 1'b0;
      end else if (ovf) begin
        out_sample_q <= '0;
        out_ovf_q    <= 1'b1;
      end else begin
        out_sample_q <= acc_y_q[SAMPLE_BITS-1:0];
        out_ovf_q    <= 1'b0;
      end
    end
  end

  assign status_o.out_full = out_valid_q & ~out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_sample_o      = out_sample_q;
  assign out_overflow_o    = out_ovf_q;

endmodule
`default_nettype wire
